FILE: hw/rtl/racd_pkg.sv
// ============================================================================
// racd_pkg
// Shared types, codes and reset values for the actuator command decoder.
// ============================================================================
package racd_pkg;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 3;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    localparam cfg_idx_t CFG_SLOW_SPEED  = 3'd0;
    localparam cfg_idx_t CFG_FAST_SPEED  = 3'd1;
    localparam cfg_idx_t CFG_START_TICKS = 3'd2;
    localparam cfg_idx_t CFG_ONE_TICKS   = 3'd3;
    localparam cfg_idx_t CFG_ZERO_TICKS  = 3'd4;

    // Configuration reset values
    localparam logic [7:0] RST_SLOW_SPEED  = 8'd128;
    localparam logic [7:0] RST_FAST_SPEED  = 8'd170;
    localparam logic [7:0] RST_START_TICKS = 8'd37;
    localparam logic [7:0] RST_ONE_TICKS   = 8'd19;
    localparam logic [7:0] RST_ZERO_TICKS  = 8'd9;

    // Transaction types
    localparam logic REQ_CMD  = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    // Unit select (high nibble)
    typedef logic [3:0] nibble_t;
    localparam nibble_t UNIT_MOTOR = 4'h1;
    localparam nibble_t UNIT_LASER = 4'h2;
    localparam nibble_t UNIT_IR    = 4'h3;
    localparam nibble_t UNIT_LED   = 4'h4;

    // Arguments (low nibble)
    localparam nibble_t ARG_LASER_ON  = 4'h1;
    localparam nibble_t ARG_LASER_OFF = 4'h2;
    localparam nibble_t ARG_IR_OFF    = 4'h1;
    localparam nibble_t ARG_IR_ON     = 4'h2;
    localparam nibble_t ARG_IR_PULSE  = 4'h3;

    // Lamp latch command
    localparam logic [7:0] CMD_LAMP = 8'h10;

    // Motor speed codes
    typedef logic [1:0] speed_code_t;
    localparam speed_code_t SPD_STOP  = 2'd0;
    localparam speed_code_t SPD_FAST  = 2'd1;
    localparam speed_code_t SPD_SLOW  = 2'd2;
    localparam speed_code_t SPD_FAST2 = 2'd3;

    // IR sequencer phases with special intervals
    typedef logic [2:0] ir_phase_t;
    localparam ir_phase_t PH_START = 3'd0;
    localparam ir_phase_t PH_LONG  = 3'd4;

    function automatic logic [7:0] speed_of(
        input speed_code_t code,
        input logic [7:0]  slow,
        input logic [7:0]  fast
    );
        logic [7:0] val;
        case (code)
            SPD_FAST:  val = fast;
            SPD_SLOW:  val = slow;
            SPD_FAST2: val = fast;
            default:   val = 8'd0;
        endcase
        return val;
    endfunction

endpackage

FILE: hw/rtl/robot_actuator_command_decoder_core.sv
// ============================================================================
// robot_actuator_command_decoder_core
// Command byte and timer tick decoder driving motors, laser, LEDs, lamp
// and an eight-phase IR burst sequencer.
// ============================================================================
// Every accepted transaction (command byte or timer tick) yields exactly one
// result transaction carrying all actuator outputs after the update. The
// block sustains one transaction per clock while m_ready is high: an input
// register holds the incoming transaction, one pass of shallow decode logic
// updates the actuator state and loads the result register, so a transaction
// passes through the input register and then the result register before
// m_valid rises. The input register frees as soon as the result register
// can take the next result, so s_ready stays high while one result waits on
// m_ready and drops only when both stages are full. Configuration writes
// (speeds and IR intervals) take effect for later commands and interval
// loads; an interval already loaded keeps running until replaced.
// ============================================================================
module robot_actuator_command_decoder_core (
    input  logic                      aclk,
    input  logic                      aresetn,
    // configuration write port
    input  logic                      cfg_wr_en,
    input  racd_pkg::cfg_idx_t        cfg_index,
    input  logic [7:0]                cfg_wdata,
    // input channel
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic                      s_req_type,
    input  logic [7:0]                s_cmd_byte,
    // result channel
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [7:0]                m_speed_a,
    output logic [7:0]                m_speed_b,
    output logic                      m_dir_a,
    output logic                      m_dir_b,
    output logic                      m_laser_on,
    output logic [2:0]                m_led_bits,
    output logic                      m_carrier_on,
    output logic                      m_detector_pulse,
    output logic                      m_lamp_on,
    output logic [2:0]                m_ir_phase_out
);
    import racd_pkg::*;

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [7:0] slow_speed_reg;
    logic [7:0] fast_speed_reg;
    logic [7:0] start_ticks_reg;
    logic [7:0] one_ticks_reg;
    logic [7:0] zero_ticks_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slow_speed_reg  <= RST_SLOW_SPEED;
            fast_speed_reg  <= RST_FAST_SPEED;
            start_ticks_reg <= RST_START_TICKS;
            one_ticks_reg   <= RST_ONE_TICKS;
            zero_ticks_reg  <= RST_ZERO_TICKS;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_SLOW_SPEED:  slow_speed_reg  <= cfg_wdata;
                CFG_FAST_SPEED:  fast_speed_reg  <= cfg_wdata;
                CFG_START_TICKS: start_ticks_reg <= cfg_wdata;
                CFG_ONE_TICKS:   one_ticks_reg   <= cfg_wdata;
                CFG_ZERO_TICKS:  zero_ticks_reg  <= cfg_wdata;
                default: ;  // out-of-range index ignored
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Pipeline handshake
    // ---------------------------------------------------------------
    logic       in_valid_reg;
    logic       in_type_reg;
    logic [7:0] in_cmd_reg;
    logic       m_valid_reg;
    logic       advance;     // input stage moves into the result register
    logic       s_accept;

    assign advance  = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready  = !in_valid_reg || advance;
    assign s_accept = s_valid && s_ready;
    assign m_valid  = m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (s_accept) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_type_reg <= s_req_type;
            in_cmd_reg  <= s_cmd_byte;
        end
    end

    // ---------------------------------------------------------------
    // Actuator and sequencer state
    // ---------------------------------------------------------------
    logic [7:0] speed_a_reg,  speed_a_next;
    logic [7:0] speed_b_reg,  speed_b_next;
    logic       dir_a_reg,    dir_a_next;
    logic       dir_b_reg,    dir_b_next;
    logic       laser_reg,    laser_next;
    logic [2:0] led_reg,      led_next;
    logic       ir_en_reg,    ir_en_next;
    ir_phase_t  ir_phase_reg, ir_phase_next;
    logic       carrier_reg,  carrier_next;
    logic [7:0] interval_reg, interval_next;
    logic [7:0] tick_cnt_reg, tick_cnt_next;
    logic       lamp_reg,     lamp_next;
    logic       pulse;

    nibble_t     unit;
    nibble_t     arg;
    speed_code_t code_a;
    speed_code_t code_b;
    logic [7:0]  tick_inc;

    assign unit     = in_cmd_reg[7:4];
    assign arg      = in_cmd_reg[3:0];
    assign code_a   = arg[3:2];
    assign code_b   = arg[1:0];
    assign tick_inc = tick_cnt_reg + 8'd1;

    always_comb begin
        speed_a_next  = speed_a_reg;
        speed_b_next  = speed_b_reg;
        dir_a_next    = dir_a_reg;
        dir_b_next    = dir_b_reg;
        laser_next    = laser_reg;
        led_next      = led_reg;
        ir_en_next    = ir_en_reg;
        ir_phase_next = ir_phase_reg;
        carrier_next  = carrier_reg;
        interval_next = interval_reg;
        tick_cnt_next = tick_cnt_reg;
        lamp_next     = lamp_reg;
        pulse         = 1'b0;

        if (in_type_reg == REQ_TICK) begin
            // Sequencer fires when the incremented count hits the interval
            if (tick_inc == interval_reg) begin
                tick_cnt_next = 8'd0;
                if (ir_en_reg) begin
                    if (ir_phase_reg == PH_START) begin
                        interval_next = start_ticks_reg;
                    end else if (ir_phase_reg == PH_LONG) begin
                        interval_next = one_ticks_reg;
                    end else begin
                        interval_next = zero_ticks_reg;
                    end
                    carrier_next  = ~ir_phase_reg[0];  // odd phases burst
                    ir_phase_next = ir_phase_reg + 3'd1;
                end
            end else begin
                tick_cnt_next = tick_inc;
            end
        end else begin
            if (in_cmd_reg == CMD_LAMP) begin
                lamp_next = 1'b1;
            end
            case (unit)
                UNIT_MOTOR: begin
                    dir_a_next   = (code_a != SPD_FAST);
                    dir_b_next   = (code_b == SPD_FAST);
                    speed_a_next = speed_of(code_a, slow_speed_reg, fast_speed_reg);
                    speed_b_next = speed_of(code_b, slow_speed_reg, fast_speed_reg);
                end
                UNIT_LASER: begin
                    if (arg == ARG_LASER_ON) begin
                        laser_next = 1'b1;
                    end else if (arg == ARG_LASER_OFF) begin
                        laser_next = 1'b0;
                    end
                end
                UNIT_IR: begin
                    // IR off rewinds the sequencer but keeps the tick count
                    if (arg == ARG_IR_OFF) begin
                        ir_en_next    = 1'b0;
                        carrier_next  = 1'b0;
                        ir_phase_next = PH_START;
                        interval_next = start_ticks_reg;
                    end else if (arg == ARG_IR_ON) begin
                        ir_en_next   = 1'b1;
                        carrier_next = 1'b1;
                    end else if (arg == ARG_IR_PULSE) begin
                        pulse = 1'b1;
                    end
                end
                UNIT_LED: begin
                    led_next = arg[2:0];
                end
                default: ;  // unknown unit ignored
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            speed_a_reg  <= 8'd0;
            speed_b_reg  <= 8'd0;
            dir_a_reg    <= 1'b1;
            dir_b_reg    <= 1'b1;
            laser_reg    <= 1'b0;
            led_reg      <= 3'd0;
            ir_en_reg    <= 1'b1;
            ir_phase_reg <= PH_START;
            carrier_reg  <= 1'b1;
            interval_reg <= RST_START_TICKS;
            tick_cnt_reg <= 8'd0;
            lamp_reg     <= 1'b0;
        end else if (advance) begin
            speed_a_reg  <= speed_a_next;
            speed_b_reg  <= speed_b_next;
            dir_a_reg    <= dir_a_next;
            dir_b_reg    <= dir_b_next;
            laser_reg    <= laser_next;
            led_reg      <= led_next;
            ir_en_reg    <= ir_en_next;
            ir_phase_reg <= ir_phase_next;
            carrier_reg  <= carrier_next;
            interval_reg <= interval_next;
            tick_cnt_reg <= tick_cnt_next;
            lamp_reg     <= lamp_next;
        end
    end

    // ---------------------------------------------------------------
    // Result register: snapshot of the outputs after the update
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (advance) begin
            m_speed_a        <= speed_a_next;
            m_speed_b        <= speed_b_next;
            m_dir_a          <= dir_a_next;
            m_dir_b          <= dir_b_next;
            m_laser_on       <= laser_next;
            m_led_bits       <= led_next;
            m_carrier_on     <= carrier_next;
            m_detector_pulse <= pulse;
            m_lamp_on        <= lamp_next;
            m_ir_phase_out   <= ir_phase_next;
        end
    end

endmodule
